// ----- hdl/fpa_pkg.sv -----
`default_nettype none
package fpa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned FuncW    = 4;
  localparam int unsigned DivW     = WordW + FracBits;
  // One cell per quotient bit; the dividend carries FracBits extra low bits
  localparam int unsigned NumCells = DivW;

  typedef enum logic [FuncW-1:0] {
    OpAdd = 4'd0, OpSub = 4'd1, OpMul = 4'd2, OpDiv = 4'd3,
    OpLt = 4'd4, OpGt = 4'd5, OpLe = 4'd6, OpGe = 4'd7,
    OpEq = 4'd8, OpNe = 4'd9, OpMin = 4'd10, OpMax = 4'd11,
    OpInc = 4'd12, OpDec = 4'd13, OpToInt = 4'd14, OpFromInt = 4'd15
  } op_e;

  typedef struct packed {
    logic               valid;
    logic               div;      // division in progress
    logic               neg;      // quotient sign
    logic               dz;
    logic [DivW-1:0]    dvd;      // magnitude of dividend, shifted out msb first
    logic [WordW-1:0]   dvs;      // magnitude of divisor
    logic [WordW:0]     rem;
    logic [DivW-1:0]    quo;
    logic [WordW-1:0]   word;     // result for everything but division
    logic               cmp;
  } stage_t;

endpackage
`default_nettype wire

// ----- hdl/fpa_if.sv -----
`default_nettype none
interface fpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpa_pkg::FuncW-1:0]     func;
  logic signed [fpa_pkg::WordW-1:0] operand_a;
  logic signed [fpa_pkg::WordW-1:0] operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [fpa_pkg::WordW-1:0] result_word;
  logic                          compare_flag;
  logic                          divide_by_zero;
  modport source (output valid, result_word, compare_flag, divide_by_zero, input ready);
  modport sink (input valid, result_word, compare_flag, divide_by_zero, output ready);
endinterface
`default_nettype wire

// ----- hdl/fixed_point_alu_q24_8_top.sv -----
`default_nettype none
// Every opcode passes through one decode stage, a row of 40 division cells
// (one quotient bit each) and an output register.
// Throughput: one transaction per cycle; the whole row advances when the output
// register is free or being drained.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
module fixed_point_alu_q24_8_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpa_in_if.sink    in_i,
  fpa_out_if.source out_o
);
  import fpa_pkg::*;

  stage_t           chain [NumCells+1];
  logic             en;
  logic             out_valid_q;
  logic [WordW-1:0] word_q;
  logic             cmp_q, dz_q;
  logic [WordW-1:0] q_fix;
  stage_t           last;

  assign en = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  fpa_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_i.valid),
    .func_i(in_i.func),
    .a_i(in_i.operand_a),
    .b_i(in_i.operand_b),
    .stage_o(chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    fpa_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .stage_i(chain[g]),
      .stage_o(chain[g+1])
    );
  end

  assign last  = chain[NumCells];
  assign q_fix = last.neg ? (~last.quo[WordW-1:0] + 1'b1) : last.quo[WordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= last.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      word_q <= last.div ? q_fix : last.word;
      cmp_q  <= last.cmp;
      dz_q   <= last.dz;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_word    = signed'(word_q);
  assign out_o.compare_flag   = cmp_q;
  assign out_o.divide_by_zero = dz_q;
endmodule
`default_nettype wire

// ----- hdl/fpa_front.sv -----
`default_nettype none
// Operand decode: everything except division finishes here; division is set up
module fpa_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [fpa_pkg::FuncW-1:0]     func_i,
  input  wire logic [fpa_pkg::WordW-1:0]     a_i,
  input  wire logic [fpa_pkg::WordW-1:0]     b_i,
  output fpa_pkg::stage_t                    stage_o
);
  import fpa_pkg::*;

  logic signed [2*WordW-1:0] prod;
  logic signed [2*WordW-1:0] prod_q;
  logic                      mul_q;
  logic                      valid_q;
  stage_t                    s_d, s_q;
  logic                      lt, eq;
  logic [WordW-1:0]          mag_a, mag_b, ti;
  logic signed [WordW-1:0]   sa, sb;
  op_e                       op;

  assign sa = signed'(a_i);
  assign sb = signed'(b_i);
  assign op = op_e'(func_i);
  assign prod = sa * sb;
  assign lt = sa < sb;
  assign eq = a_i == b_i;
  assign mag_a = a_i[WordW-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[WordW-1] ? (~b_i + 1'b1) : b_i;
  // truncate toward zero: shift the magnitude, restore the sign
  assign ti = a_i[WordW-1] ? ~(mag_a >> FracBits) + 1'b1 : (a_i >>> FracBits);

  always_comb begin
    s_d       = '0;
    s_d.valid = valid_i;
    s_d.dvd   = {mag_a, {FracBits{1'b0}}};
    s_d.dvs   = mag_b;
    s_d.neg   = a_i[WordW-1] ^ b_i[WordW-1];
    unique case (op)
      OpAdd:     s_d.word = a_i + b_i;
      OpSub:     s_d.word = a_i - b_i;
      OpMul:     s_d.word = '0;
      OpDiv: begin
        s_d.div = (b_i != '0);
        s_d.dz  = (b_i == '0);
      end
      OpLt:      s_d.cmp = lt;
      OpGt:      s_d.cmp = !lt && !eq;
      OpLe:      s_d.cmp = lt || eq;
      OpGe:      s_d.cmp = !lt;
      OpEq:      s_d.cmp = eq;
      OpNe:      s_d.cmp = !eq;
      OpMin:     s_d.word = lt ? a_i : b_i;
      OpMax:     s_d.word = (!lt && !eq) ? a_i : b_i;
      OpInc:     s_d.word = a_i + 1'b1;
      OpDec:     s_d.word = a_i - 1'b1;
      OpToInt:   s_d.word = ti;
      OpFromInt: s_d.word = a_i << FracBits;
      default:   s_d.word = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mul_q   <= 1'b0;
    end else if (en_i) begin
      valid_q <= s_d.valid;
      mul_q   <= valid_i && (op == OpMul);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      prod_q <= prod;
    end
  end

  always_comb begin
    stage_o       = s_q;
    stage_o.valid = valid_q;
    if (mul_q) stage_o.word = WordW'(prod_q >>> FracBits);
  end
endmodule
`default_nettype wire

// ----- hdl/fpa_cell.sv -----
`default_nettype none
// One restoring-division cell: ShiftPer quotient bits per cycle while en_i is high
module fpa_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  fpa_pkg::stage_t      stage_i,
  output fpa_pkg::stage_t      stage_o
);
  import fpa_pkg::*;

  localparam int unsigned ShiftPer = (DivW + NumCells - 1) / NumCells;

  stage_t           s_d, s_q;
  logic             valid_q;
  logic [WordW+1:0] trial;

  always_comb begin
    s_d   = stage_i;
    trial = '0;
    for (int k = 0; k < ShiftPer; k++) begin
      trial     = {s_d.rem, s_d.dvd[DivW-1]};
      s_d.dvd   = s_d.dvd << 1;
      if (trial >= {2'b00, s_d.dvs}) begin
        s_d.rem = (WordW+1)'(trial - {2'b00, s_d.dvs});
        s_d.quo = {s_d.quo[DivW-2:0], 1'b1};
      end else begin
        s_d.rem = trial[WordW:0];
        s_d.quo = {s_d.quo[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= s_d.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  always_comb begin
    stage_o       = s_q;
    stage_o.valid = valid_q;
  end
endmodule
`default_nettype wire

// ----- hdl/fpa_checker.sv -----
`default_nettype none
module fpa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cmp,
  input wire logic dz,
  input wire logic [fpa_pkg::WordW-1:0] word
);
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(cmp && dz)) else $error("both flags set");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && dz) |-> (word == '0)) else $error("dz with nonzero word");
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && cmp) |-> (word == '0)) else $error("compare with nonzero word");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid || out_ready) |-> in_ready) else $error("stalled while free");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(word))) else $error("output dropped");
endmodule

bind fixed_point_alu_q24_8_top fpa_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .cmp(out_o.compare_flag), .dz(out_o.divide_by_zero), .word(out_o.result_word)
);
`default_nettype wire
